// ===== rtl/fixed_capacity_key_value_table_defines.svh =====
// Assertion macros shared by the key/value table RTL.
// No dependencies; the using module supplies clk and arst_n.
`ifndef FIXED_CAPACITY_KEY_VALUE_TABLE_DEFINES_SVH
`define FIXED_CAPACITY_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication.
`define FCKVT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FCKVT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Invariant at every edge.
`define FCKVT_ASSERT_ALW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ===== rtl/fckvt_pkg.sv =====
// Shared types and constants for the fixed-capacity key/value table.
// No dependencies.
`default_nettype none

package fckvt_pkg;

	localparam int DEF_CAPACITY   = 256;
	localparam int DEF_KEY_BITS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 80;
	localparam int M_TUSER_W = 1;

	typedef enum logic [2:0] {
		REQ_INSERT     = 3'd0,
		REQ_UPDATE     = 3'd1,
		REQ_UPSERT     = 3'd2,
		REQ_ERASE      = 3'd3,
		REQ_CONTAINS   = 3'd4,
		REQ_GET_KEY    = 3'd5,
		REQ_GET_INDEX  = 3'd6
	} req_type_t;

	// Strobes from the sequencer to the entry store.
	typedef struct packed {
		logic rd;
		logic wr_key;
		logic wr_val;
	} mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fckvt_store.sv =====
// Key and value memories: one write port and one registered read port each.
// Depends on fckvt_pkg.
`default_nettype none

module fckvt_store #(
	parameter int CAPACITY   = 256,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  wire                          clk,
	input  wire fckvt_pkg::mem_ctl_t     ctl,
	input  wire [$clog2(CAPACITY)-1:0]   rd_addr,
	input  wire [$clog2(CAPACITY)-1:0]   wr_addr,
	input  wire [KEY_BITS-1:0]           wr_key,
	input  wire [VALUE_BITS-1:0]         wr_val,
	output logic [KEY_BITS-1:0]          rd_key,
	output logic [VALUE_BITS-1:0]        rd_val
);
	import fckvt_pkg::*;

	logic [KEY_BITS-1:0]   key_mem [CAPACITY];
	logic [VALUE_BITS-1:0] val_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (ctl.wr_key) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (ctl.wr_val) begin
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_key <= key_mem[rd_addr];
			rd_val <= val_mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fixed_capacity_key_value_table.sv =====
// Top level of the fixed-capacity unordered key/value table: request
// sequencer, key comparator and result register. Depends on fckvt_pkg,
// fckvt_store and fixed_capacity_key_value_table_defines.svh.
//
//   channel   dir  ports                       transfer
//   request   in   s_tvalid/s_tready/s_tdata   one request per transfer
//                  /s_tuser
//   result    out  m_tvalid/m_tready/m_tdata   one result per request
//                  /m_tuser
//
// Key searches read one entry per cycle through the single read port of the
// entry store; a miss scans every live entry, an erase that hits then moves
// the last entry into the hole, get_by_index reads the indexed entry, and an
// index not below the count or an unused type goes straight to the result.
// s_tready is low from acceptance until the result transfer completes.
// Reset clears the entry count and the sequencer state; the memories need no clearing pass.
`default_nettype none

module fixed_capacity_key_value_table #(
	parameter int CAPACITY   = fckvt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS   = fckvt_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS = fckvt_pkg::DEF_VALUE_BITS
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// [31:0] req_key, [63:32] req_value, [71:64] req_index
	input  wire [fckvt_pkg::S_TDATA_W-1:0]    s_tdata,
	// [2:0] req_type
	input  wire [fckvt_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// [31:0] out_key, [63:32] out_value, [72:64] entry_count, [79:73] zero
	output logic [fckvt_pkg::M_TDATA_W-1:0]   m_tdata,
	// [0] ok
	output logic [fckvt_pkg::M_TUSER_W-1:0]   m_tuser
);
	import fckvt_pkg::*;

	`include "fixed_capacity_key_value_table_defines.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SCAN = 7'b0000010,
		ST_ACT  = 7'b0000100,
		ST_MVWR = 7'b0001000,
		ST_IDX  = 7'b0010000,
		ST_IDXW = 7'b0100000,
		ST_RESP = 7'b1000000
	} state_t;

	state_t                state_q, state_d;
	req_type_t             type_q;
	logic [31:0]           key_q;
	logic [31:0]           val_q;
	logic [7:0]            idx_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         ptr_q;
	logic                  cmp_v_q;
	logic [AW-1:0]         cmp_pos_q;
	logic                  found_q;
	logic [AW-1:0]         pos_q;
	logic [VALUE_BITS-1:0] hit_val_q;
	logic                  ok_q;
	logic [31:0]           okey_q;
	logic [31:0]           oval_q;

	mem_ctl_t              ctl;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [VALUE_BITS-1:0] wr_val;
	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;

	logic                  accept;
	req_type_t             in_type;
	logic [15:0]           in_idx_ext;
	logic [15:0]           cnt_ext;
	logic                  in_idx_ok;
	logic [63:0]           key_ext;
	logic [63:0]           val_ext;
	logic [KEY_BITS-1:0]   key_cmp;
	logic [VALUE_BITS-1:0] val_w;
	logic [15:0]           idx_ext;
	logic [63:0]           rdk_ext;
	logic [63:0]           rdv_ext;
	logic [63:0]           hit_ext;
	logic [CW-1:0]         last_w;
	logic                  hit;
	logic                  issue;
	logic                  room;
	logic                  act_ok;
	logic                  do_insert;

	assign accept     = s_tvalid && s_tready;
	assign in_type    = req_type_t'(s_tuser[2:0]);
	assign in_idx_ext = 16'(s_tdata[71:64]);
	assign cnt_ext    = 16'(count_q);
	assign in_idx_ok  = in_idx_ext < cnt_ext;

	assign key_ext = 64'(key_q);
	assign val_ext = 64'(val_q);
	assign key_cmp = key_ext[KEY_BITS-1:0];
	assign val_w   = val_ext[VALUE_BITS-1:0];
	assign idx_ext = 16'(idx_q);
	assign rdk_ext = 64'(rd_key);
	assign rdv_ext = 64'(rd_val);
	assign hit_ext = 64'(hit_val_q);
	assign last_w  = count_q - CW'(1);

	assign hit   = cmp_v_q && (rd_key == key_cmp);
	assign issue = ptr_q < count_q;
	assign room  = count_q < CW'(CAPACITY);

	// Outcome of the action step once the search has finished.
	always_comb begin
		do_insert = 1'b0;
		act_ok    = 1'b0;
		unique case (type_q)
			REQ_INSERT, REQ_UPDATE, REQ_UPSERT: begin
				if (found_q) begin
					act_ok = type_q != REQ_INSERT;
				end else begin
					do_insert = (type_q != REQ_UPDATE) && room;
					act_ok    = do_insert;
				end
			end
			REQ_ERASE, REQ_CONTAINS, REQ_GET_KEY: begin
				act_ok = found_q;
			end
			default: begin
				act_ok = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		rd_addr = ptr_q[AW-1:0];
		wr_addr = pos_q;
		wr_key  = key_cmp;
		wr_val  = val_w;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					priority case (in_type)
						REQ_INSERT, REQ_UPDATE, REQ_UPSERT,
						REQ_ERASE, REQ_CONTAINS, REQ_GET_KEY: begin
							state_d = ST_SCAN;
						end
						REQ_GET_INDEX: begin
							state_d = in_idx_ok ? ST_IDX : ST_RESP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_SCAN: begin
				ctl.rd = issue;
				if (hit || (!cmp_v_q && !issue)) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				state_d = ST_RESP;
				if (found_q && (type_q == REQ_UPDATE || type_q == REQ_UPSERT)) begin
					ctl.wr_val = 1'b1;
				end
				if (do_insert) begin
					wr_addr    = count_q[AW-1:0];
					ctl.wr_key = 1'b1;
					ctl.wr_val = 1'b1;
				end
				if (found_q && type_q == REQ_ERASE) begin
					// fetch the last entry to fill the hole
					ctl.rd  = 1'b1;
					rd_addr = last_w[AW-1:0];
					state_d = ST_MVWR;
				end
			end
			ST_MVWR: begin
				wr_key     = rd_key;
				wr_val     = rd_val;
				ctl.wr_key = 1'b1;
				ctl.wr_val = 1'b1;
				state_d    = ST_RESP;
			end
			ST_IDX: begin
				ctl.rd  = 1'b1;
				rd_addr = idx_ext[AW-1:0];
				state_d = ST_IDXW;
			end
			ST_IDXW: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			cmp_v_q <= 1'b0;
			ptr_q   <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				ptr_q   <= '0;
				cmp_v_q <= 1'b0;
				found_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (issue) begin
					ptr_q <= ptr_q + CW'(1);
				end
				cmp_v_q <= issue;
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_ACT && do_insert) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_MVWR) begin
				count_q <= last_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= in_type;
			key_q  <= s_tdata[31:0];
			val_q  <= s_tdata[63:32];
			idx_q  <= s_tdata[71:64];
			ok_q   <= 1'b0;
			okey_q <= s_tdata[31:0];
			oval_q <= '0;
		end
		if (state_q == ST_SCAN) begin
			if (issue) begin
				cmp_pos_q <= ptr_q[AW-1:0];
			end
			if (hit) begin
				pos_q     <= cmp_pos_q;
				hit_val_q <= rd_val;
			end
		end
		if (state_q == ST_ACT) begin
			ok_q <= act_ok;
			if (found_q && type_q == REQ_GET_KEY) begin
				oval_q <= hit_ext[31:0];
			end
		end
		if (state_q == ST_IDXW) begin
			ok_q   <= 1'b1;
			okey_q <= rdk_ext[31:0];
			oval_q <= rdv_ext[31:0];
		end
	end

	fckvt_store #(
		.CAPACITY   (CAPACITY),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_val  (wr_val),
		.rd_key  (rd_key),
		.rd_val  (rd_val)
	);

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_RESP;
	assign m_tuser  = ok_q;
	assign m_tdata  = {7'b0, cnt_ext[8:0], oval_q, okey_q};

	`FCKVT_ASSERT_ALW(a_no_overlap, !(s_tready && m_tvalid), "ready while result pending")
	`FCKVT_ASSERT_ALW(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
	`FCKVT_ASSERT_NXT(a_busy_after_accept, accept, !s_tready, "ready right after a transfer")
	`FCKVT_ASSERT_IMP(a_count_change, !$stable(count_q), $past(state_q == ST_ACT) || $past(state_q == ST_MVWR), "count changed outside update step")

endmodule

`default_nettype wire
